>>> sv/dtsv_pkg.sv
// Package for the debounced timed servo valve: constants, register map and helpers.
`default_nettype none
package dtsv_pkg;

  localparam int unsigned MaxAngle = 270;

  localparam int unsigned AngleW   = 9;
  localparam int unsigned PulseW   = 13;
  localparam int unsigned CmpW     = 11;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned DebW     = 16;
  localparam int unsigned HoldW    = 24;
  localparam int unsigned ProdW    = AngleW + PulseW;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned AddrW    = 5;

  localparam logic [CmpW-1:0] CmpMin = CmpW'(400);
  localparam logic [CmpW-1:0] CmpMax = CmpW'(2000);

  localparam int unsigned      DivAngleShift = 31;
  localparam logic [31:0]      DivAngleMul   =
    32'(((64'd1 << DivAngleShift) + 64'(MaxAngle) - 64'd1) / 64'(MaxAngle));

  localparam int unsigned      DivFiveShift = 18;
  localparam logic [15:0]      DivFiveMul   = 16'(((1 << DivFiveShift) + 4) / 5);

  localparam logic [DebW-1:0]   DebounceReset = DebW'(50);
  localparam logic [HoldW-1:0]  HoldReset     = HoldW'(30000);
  localparam logic [AngleW-1:0] OpenReset     = AngleW'(270);
  localparam logic [AngleW-1:0] CloseReset    = AngleW'(0);
  localparam logic [PulseW-1:0] MinPulseReset = PulseW'(500);
  localparam logic [PulseW-1:0] MaxPulseReset = PulseW'(2500);

  typedef enum logic [2:0] {
    RegDebounce = 3'd0,
    RegHold     = 3'd1,
    RegOpen     = 3'd2,
    RegClose    = 3'd3,
    RegMinPulse = 3'd4,
    RegMaxPulse = 3'd5
  } reg_idx_e;

  function automatic logic [AngleW-1:0] clamp_angle(input logic [AngleW-1:0] a);
    logic [AngleW-1:0] lim;
    lim = AngleW'(MaxAngle);
    return (a > lim) ? lim : a;
  endfunction

endpackage
`default_nettype wire

>>> sv/debounced_timed_servo_valve.sv
// Top level of the debounced timed servo valve: poll state, pulse mapping pipeline, APB registers.
//
//   channel   direction  handshake                 payload
//   s_axis    in         tvalid/tready             trigger_level, time_ms
//   m_axis    out        tvalid/tready             valve_open, pwm_count, servo_angle,
//                                                  edge_seen
//   apb       in/out     psel/penable/pready       six registers at 4*i
//
// One poll is taken per cycle while m_axis is not stalled; its result is registered through every stage.
// Valve state is updated at the accepting edge; three stages then form angle*span,
// the division by the maximum angle (reciprocal multiply) plus the minimum pulse, and the clamped *8/10 scaling.
// The pipeline advances only while the output register is empty or taken; a stall
// at m_axis holds every stage and drops tready at s_axis.
// Reset clears the valve state, the stage valid bits and loads the register defaults.
`default_nettype none
module debounced_timed_servo_valve (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] trigger_level, [32:1] time_ms, [39:33] zero
  input  wire logic [dtsv_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [0] valve_open, [11:1] pwm_count, [20:12] servo_angle, [21] edge_seen, [23:22] zero
  output logic [dtsv_pkg::OutDataW-1:0]      m_axis_tdata,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dtsv_pkg::AddrW-1:0]    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import dtsv_pkg::*;

  logic [DebW-1:0]   debounce_q;
  logic [HoldW-1:0]  hold_q;
  logic [AngleW-1:0] open_angle_q;
  logic [AngleW-1:0] close_angle_q;
  logic [PulseW-1:0] min_pulse_q;
  logic [PulseW-1:0] max_pulse_q;

  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    <= DebounceReset;
      hold_q        <= HoldReset;
      open_angle_q  <= OpenReset;
      close_angle_q <= CloseReset;
      min_pulse_q   <= MinPulseReset;
      max_pulse_q   <= MaxPulseReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegDebounce: debounce_q    <= pwdata[DebW-1:0];
        RegHold:     hold_q        <= pwdata[HoldW-1:0];
        RegOpen:     open_angle_q  <= pwdata[AngleW-1:0];
        RegClose:    close_angle_q <= pwdata[AngleW-1:0];
        RegMinPulse: min_pulse_q   <= pwdata[PulseW-1:0];
        RegMaxPulse: max_pulse_q   <= pwdata[PulseW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegDebounce: prdata = {{(32-DebW){1'b0}}, debounce_q};
      RegHold:     prdata = {{(32-HoldW){1'b0}}, hold_q};
      RegOpen:     prdata = {{(32-AngleW){1'b0}}, open_angle_q};
      RegClose:    prdata = {{(32-AngleW){1'b0}}, close_angle_q};
      RegMinPulse: prdata = {{(32-PulseW){1'b0}}, min_pulse_q};
      RegMaxPulse: prdata = {{(32-PulseW){1'b0}}, max_pulse_q};
      default:     prdata = 32'd0;
    endcase
  end

  // Poll state
  logic              open_q, open_d;
  logic [TimeW-1:0]  open_start_q, open_start_d;
  logic              last_level_q, last_level_d;
  logic [TimeW-1:0]  last_change_q, last_change_d;
  logic [AngleW-1:0] angle_q, angle_d;
  logic              edge_d;

  logic              advance;
  logic              s_fire;
  logic              level;
  logic [TimeW-1:0]  now;
  logic [TimeW-1:0]  open_elapsed;
  logic [TimeW-1:0]  change_elapsed;

  logic              v1_q, v2_q, v3_q, v4_q;

  assign advance       = !v4_q || m_axis_tready;
  assign s_axis_tready = advance;
  assign s_fire        = s_axis_tvalid & s_axis_tready;
  assign level         = s_axis_tdata[0];
  assign now           = s_axis_tdata[TimeW:1];
  assign open_elapsed  = now - open_start_q;
  assign change_elapsed = now - last_change_q;

  always_comb begin
    open_d        = open_q;
    open_start_d  = open_start_q;
    last_level_d  = last_level_q;
    last_change_d = last_change_q;
    angle_d       = angle_q;
    edge_d        = 1'b0;
    if (open_q) begin
      if (open_elapsed >= {{(TimeW-HoldW){1'b0}}, hold_q}) begin
        angle_d = clamp_angle(close_angle_q);
        open_d  = 1'b0;
      end
    end else if (level != last_level_q) begin
      if (change_elapsed >= {{(TimeW-DebW){1'b0}}, debounce_q}) begin
        last_change_d = now;
        last_level_d  = level;
        if (level) begin
          edge_d       = 1'b1;
          angle_d      = clamp_angle(open_angle_q);
          open_start_d = now;
          open_d       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q        <= 1'b0;
      open_start_q  <= '0;
      last_level_q  <= 1'b0;
      last_change_q <= '0;
      angle_q       <= '0;
    end else if (s_fire) begin
      open_q        <= open_d;
      open_start_q  <= open_start_d;
      last_level_q  <= last_level_d;
      last_change_q <= last_change_d;
      angle_q       <= angle_d;
    end
  end

  // Pulse mapping pipeline
  logic [PulseW-1:0]     span;
  logic [ProdW-1:0]      prod_d;
  logic [ProdW+31:0]     quot_full;
  logic [PulseW:0]       pulse_d;
  logic [PulseW+2:0]     pulse_x4;
  logic [PulseW+18:0]    cmp_full;
  logic [PulseW:0]       cmp_raw;
  logic [CmpW-1:0]       cmp_d;

  logic                  s1_open_q, s2_open_q, s3_open_q, out_open_q;
  logic                  s1_edge_q, s2_edge_q, s3_edge_q, out_edge_q;
  logic [AngleW-1:0]     s1_angle_q, s2_angle_q, s3_angle_q, out_angle_q;
  logic [ProdW-1:0]      s2_prod_q;
  logic [PulseW:0]       s3_pulse_q;
  logic [CmpW-1:0]       out_cmp_q;

  assign span      = (max_pulse_q >= min_pulse_q) ? (max_pulse_q - min_pulse_q) : '0;
  assign prod_d    = {{PulseW{1'b0}}, s1_angle_q} * {{AngleW{1'b0}}, span};
  assign quot_full = {32'd0, s2_prod_q} * {{ProdW{1'b0}}, DivAngleMul};
  assign pulse_d   = {1'b0, min_pulse_q}
                   + {1'b0, quot_full[DivAngleShift +: PulseW]};
  assign pulse_x4  = {s3_pulse_q, 2'b00};
  assign cmp_full  = {{16{1'b0}}, pulse_x4} * {{(PulseW+3){1'b0}}, DivFiveMul};
  assign cmp_raw   = cmp_full[DivFiveShift +: PulseW+1];

  always_comb begin
    if (cmp_raw < {{(PulseW+1-CmpW){1'b0}}, CmpMin}) begin
      cmp_d = CmpMin;
    end else if (cmp_raw > {{(PulseW+1-CmpW){1'b0}}, CmpMax}) begin
      cmp_d = CmpMax;
    end else begin
      cmp_d = cmp_raw[CmpW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (advance) begin
      v1_q <= s_fire;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_open_q   <= open_d;
      s1_edge_q   <= edge_d;
      s1_angle_q  <= angle_d;
      s2_open_q   <= s1_open_q;
      s2_edge_q   <= s1_edge_q;
      s2_angle_q  <= s1_angle_q;
      s2_prod_q   <= prod_d;
      s3_open_q   <= s2_open_q;
      s3_edge_q   <= s2_edge_q;
      s3_angle_q  <= s2_angle_q;
      s3_pulse_q  <= pulse_d;
      out_open_q  <= s3_open_q;
      out_edge_q  <= s3_edge_q;
      out_angle_q <= s3_angle_q;
      out_cmp_q   <= cmp_d;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {2'b00, out_edge_q, out_angle_q, out_cmp_q, out_open_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(open_q) |-> $past(s_fire))
    else $error("valve opened without an accepted poll");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_edge_q) |-> out_open_q)
    else $error("edge reported while valve closed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_cmp_q >= CmpMin && out_cmp_q <= CmpMax))
    else $error("compare value out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_angle_q <= AngleW'(MaxAngle)))
    else $error("servo angle above maximum");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && $past(advance)) |-> $past(s_fire))
    else $error("stage one filled without an accepted poll");

endmodule
`default_nettype wire
